// File: design/tnpt_pkg.sv
// ----------------------------------------------------------------------------
// tnpt_pkg
// Types and constants shared by the timed note preview table.
// ----------------------------------------------------------------------------
`default_nettype none

package tnpt_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [1:0] REQ_ON   = 2'd0;
  localparam logic [1:0] REQ_OFF  = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic EV_ON  = 1'b0;
  localparam logic EV_OFF = 1'b1;

  typedef enum logic [1:0] {
    CMD_ON,
    CMD_OFF,
    CMD_TICK
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ON,
    BK_SCAN,
    BK_FLUSH
  } back_state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        channel_found;
    logic [3:0]  channel_index;
    logic [15:0] channel_id;
    logic [6:0]  key;
    logic [6:0]  velocity;
    logic [23:0] duration_samples;
    logic [12:0] block_samples;
    logic [4:0]  channel_count;
  } in_item_t;

  typedef struct packed {
    logic        event_kind;
    logic [3:0]  out_channel;
    logic [6:0]  out_key;
    logic [6:0]  out_velocity;
    logic [11:0] sample_offset;
    logic        last;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [3:0]  chan;
    logic [15:0] ident;
    logic [6:0]  key;
    logic [6:0]  vel;
    logic [23:0] dur;
    logic [12:0] blk;
    logic [11:0] ofs;
    logic [4:0]  count;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  chan;
    logic [15:0] ident;
    logic [6:0]  note;
    logic        untimed;
    logic [23:0] remaining;
  } slot_t;

endpackage

`default_nettype wire

// File: design/tnpt_ram.sv
// ----------------------------------------------------------------------------
// tnpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tnpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: design/tnpt_front.sv
// ----------------------------------------------------------------------------
// tnpt_front
// Accepts requests, drops unusable ones and turns the rest into commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tnpt_front #(
  parameter int CHANNELS  = 16,
  parameter int MAX_BLOCK = 4096
) (
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tnpt_pkg::in_item_t in_data,
  input  wire logic              q_full,
  output logic                   q_push,
  output tnpt_pkg::cmd_t         q_cmd
);

  logic        usable;
  logic        keep;
  logic [12:0] blk_cl;
  logic [12:0] ofs_full;

  assign in_stall = q_full;

  always_comb begin
    usable   = in_data.channel_found && (32'(in_data.channel_index) < CHANNELS);
    blk_cl   = (32'(in_data.block_samples) > MAX_BLOCK) ? 13'(MAX_BLOCK)
                                                         : in_data.block_samples;
    ofs_full = (blk_cl != 13'd0) ? blk_cl - 13'd1 : 13'd0;

    q_cmd.chan  = in_data.channel_index;
    q_cmd.ident = in_data.channel_id;
    q_cmd.key   = in_data.key;
    q_cmd.vel   = in_data.velocity;
    q_cmd.dur   = in_data.duration_samples;
    q_cmd.blk   = blk_cl;
    q_cmd.ofs   = (ofs_full > 13'd4095) ? 12'hFFF : ofs_full[11:0];
    q_cmd.count = in_data.channel_count;

    unique case (in_data.req_type)
      tnpt_pkg::REQ_ON: begin
        q_cmd.kind = tnpt_pkg::CMD_ON;
        keep       = usable;
      end
      tnpt_pkg::REQ_OFF: begin
        q_cmd.kind = tnpt_pkg::CMD_OFF;
        keep       = usable;
      end
      tnpt_pkg::REQ_TICK: begin
        q_cmd.kind = tnpt_pkg::CMD_TICK;
        keep       = 1'b1;
      end
      default: begin
        q_cmd.kind = tnpt_pkg::CMD_TICK;
        keep       = 1'b0;
      end
    endcase
  end

  assign q_push = in_valid && !in_stall && keep;

endmodule

`default_nettype wire

// File: design/tnpt_cmd_fifo.sv
// ----------------------------------------------------------------------------
// tnpt_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tnpt_cmd_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire tnpt_pkg::cmd_t  push_cmd,
  input  wire logic            pop,
  output tnpt_pkg::cmd_t       head,
  output logic                 full,
  output logic                 not_empty
);

  tnpt_pkg::cmd_t                  q_r [tnpt_pkg::QDEPTH];
  logic [tnpt_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [tnpt_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [tnpt_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                            do_push;
  logic                            do_pop;

  assign full      = (cnt_r == tnpt_pkg::QCNT_W'(tnpt_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + tnpt_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + tnpt_pkg::QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + tnpt_pkg::QCNT_W'(do_push) - tnpt_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// File: design/tnpt_back.sv
// ----------------------------------------------------------------------------
// tnpt_back
// Executes commands against the slot table and drives the event register.
// ----------------------------------------------------------------------------
`default_nettype none

module tnpt_back #(
  parameter int SLOTS = 16,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cmd_valid,
  input  wire tnpt_pkg::cmd_t      cmd,
  output logic                     cmd_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output tnpt_pkg::out_item_t      out_data
);

  localparam int SW = $bits(tnpt_pkg::slot_t);

  tnpt_pkg::back_state_t        state_r, state_nxt;
  tnpt_pkg::cmd_t               cmd_r, cmd_nxt;
  logic [SLOTS-1:0]             busy_r, busy_nxt;
  logic [IDX_W-1:0]             idx_r, idx_nxt;
  logic [tnpt_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         hold_vld_r, hold_vld_nxt;
  tnpt_pkg::out_item_t          hold_r, hold_nxt;
  logic                         out_vld_r, out_vld_nxt;
  tnpt_pkg::out_item_t          out_data_r, out_data_nxt;

  logic                         rd_en;
  logic [IDX_W-1:0]             rd_addr;
  logic                         wr_en;
  logic [IDX_W-1:0]             wr_addr;
  tnpt_pkg::slot_t              wr_slot;
  tnpt_pkg::slot_t              rd_slot;
  logic [SW-1:0]                rd_bits;

  logic                         out_free;
  logic                         have_free;
  logic [IDX_W-1:0]             free_idx;
  logic                         slot_busy;
  logic                         match_off;
  logic                         tick_live;
  logic                         expire;
  logic                         free_slot;
  logic                         emit;
  logic                         ev_take;
  logic                         scan_go;
  logic                         scan_last;
  tnpt_pkg::out_item_t          new_ev;
  tnpt_pkg::out_item_t          on_ev;

  tnpt_ram #(
    .WIDTH (SW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (SW'(wr_slot)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_bits)
  );

  assign rd_slot   = tnpt_pkg::slot_t'(rd_bits);
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_vld_r || !out_stall;

  always_comb begin
    have_free = 1'b0;
    free_idx  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        have_free = 1'b1;
        free_idx  = IDX_W'(i);
      end
    end
  end

  always_comb begin
    slot_busy = busy_r[idx_r];
    match_off = (cmd_r.kind == tnpt_pkg::CMD_OFF) && slot_busy &&
                (rd_slot.ident == cmd_r.ident) && (rd_slot.note == cmd_r.key);
    tick_live = (cmd_r.kind == tnpt_pkg::CMD_TICK) && slot_busy && !rd_slot.untimed;
    expire    = tick_live && (rd_slot.remaining <= {11'd0, cmd_r.blk});
    free_slot = match_off || expire;
    emit      = match_off || (expire && ({1'b0, rd_slot.chan} < cmd_r.count));
    ev_take   = emit && (cnt_r < tnpt_pkg::CNT_W'(tnpt_pkg::MAX_RESULTS));
    scan_go   = !(ev_take && hold_vld_r && !out_free);
    scan_last = (idx_r == IDX_W'(SLOTS - 1));

    new_ev.event_kind    = tnpt_pkg::EV_OFF;
    new_ev.out_channel   = rd_slot.chan;
    new_ev.out_key       = rd_slot.note;
    new_ev.out_velocity  = 7'd0;
    new_ev.sample_offset = (cmd_r.kind == tnpt_pkg::CMD_TICK) ? cmd_r.ofs : 12'd0;
    new_ev.last          = 1'b0;

    on_ev.event_kind    = tnpt_pkg::EV_ON;
    on_ev.out_channel   = cmd_r.chan;
    on_ev.out_key       = cmd_r.key;
    on_ev.out_velocity  = cmd_r.vel;
    on_ev.sample_offset = 12'd0;
    on_ev.last          = 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tnpt_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          state_nxt = (cmd.kind == tnpt_pkg::CMD_ON) ? tnpt_pkg::BK_ON : tnpt_pkg::BK_SCAN;
        end
      end
      tnpt_pkg::BK_ON: begin
        if (out_free) begin
          state_nxt = tnpt_pkg::BK_IDLE;
        end
      end
      tnpt_pkg::BK_SCAN: begin
        if (scan_go && scan_last) begin
          state_nxt = tnpt_pkg::BK_FLUSH;
        end
      end
      tnpt_pkg::BK_FLUSH: begin
        if (!hold_vld_r || out_free) begin
          state_nxt = tnpt_pkg::BK_IDLE;
        end
      end
      default: state_nxt = tnpt_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop      = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = idx_r;
    wr_en        = 1'b0;
    wr_addr      = idx_r;
    wr_slot      = rd_slot;
    busy_nxt     = busy_r;
    idx_nxt      = idx_r;
    cmd_nxt      = cmd_r;
    cnt_nxt      = cnt_r;
    hold_vld_nxt = hold_vld_r;
    hold_nxt     = hold_r;
    out_vld_nxt  = out_vld_r && out_stall;
    out_data_nxt = out_data_r;

    unique case (state_r)
      tnpt_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          cnt_nxt = '0;
          idx_nxt = '0;
          if (cmd.kind != tnpt_pkg::CMD_ON) begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end
        end
      end
      tnpt_pkg::BK_ON: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = on_ev;
          if (have_free) begin
            wr_en             = 1'b1;
            wr_addr           = free_idx;
            wr_slot.chan      = cmd_r.chan;
            wr_slot.ident     = cmd_r.ident;
            wr_slot.note      = cmd_r.key;
            wr_slot.untimed   = (cmd_r.dur == 24'd0);
            wr_slot.remaining = cmd_r.dur;
            busy_nxt[free_idx] = 1'b1;
          end
        end
      end
      tnpt_pkg::BK_SCAN: begin
        if (scan_go) begin
          if (free_slot) begin
            busy_nxt[idx_r] = 1'b0;
          end
          if (tick_live && !expire) begin
            wr_en             = 1'b1;
            wr_slot.remaining = rd_slot.remaining - {11'd0, cmd_r.blk};
          end
          if (ev_take) begin
            cnt_nxt      = cnt_r + tnpt_pkg::CNT_W'(1);
            hold_vld_nxt = 1'b1;
            hold_nxt     = new_ev;
            if (hold_vld_r) begin
              out_vld_nxt  = 1'b1;
              out_data_nxt = hold_r;
            end
          end
          if (!scan_last) begin
            idx_nxt = idx_r + IDX_W'(1);
            rd_en   = 1'b1;
            rd_addr = idx_r + IDX_W'(1);
          end
        end
      end
      tnpt_pkg::BK_FLUSH: begin
        if (hold_vld_r && out_free) begin
          out_vld_nxt       = 1'b1;
          out_data_nxt      = hold_r;
          out_data_nxt.last = 1'b1;
          hold_vld_nxt      = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= tnpt_pkg::BK_IDLE;
      busy_r     <= '0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      cnt_r      <= '0;
      idx_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      busy_r     <= busy_nxt;
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      cnt_r      <= cnt_nxt;
      idx_r      <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    hold_r     <= hold_nxt;
    out_data_r <= out_data_nxt;
  end

  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tnpt_pkg::BK_IDLE) |-> !hold_vld_r)
    else $error("held event left over in idle");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= tnpt_pkg::CNT_W'(tnpt_pkg::MAX_RESULTS))
    else $error("event count over limit");

  a_on_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tnpt_pkg::BK_ON && out_free) |=> (out_vld_r && out_data_r.last))
    else $error("note-on not delivered as final event");

  a_scan_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tnpt_pkg::BK_SCAN && !scan_go) |=>
      (state_r == tnpt_pkg::BK_SCAN && $stable(idx_r)))
    else $error("scan advanced while stalled");

endmodule

`default_nettype wire

// File: design/timed_note_preview_table_unit.sv
// ----------------------------------------------------------------------------
// timed_note_preview_table_unit
// Table of sounding preview notes with note-on, note-off and timed expiry.
// ----------------------------------------------------------------------------
//  port group | dir | handshake            | payload
//  in_        | in  | in_valid / in_stall  | tnpt_pkg::in_item_t
//  out_       | out | out_valid / out_stall| tnpt_pkg::out_item_t
//
//  Note-on: the command is registered from the queue head, then written to the
//  event register once the output is free. Note-off and block tick: a scan of one
//  slot per cycle, unless the output stalls, through the single RAM read port.
//  Ignored requests are taken while the queue is not full and produce nothing.
//  Reset clears the busy flags; the table is usable right after.
//  A stalled output can pause the scan; the two-entry queue takes input until full.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_note_preview_table_unit #(
  parameter int SLOTS     = 16,
  parameter int CHANNELS  = 16,
  parameter int MAX_BLOCK = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire tnpt_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output tnpt_pkg::out_item_t       out_data
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_not_empty;
  tnpt_pkg::cmd_t q_cmd;
  tnpt_pkg::cmd_t q_head;

  tnpt_front #(
    .CHANNELS  (CHANNELS),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  tnpt_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  tnpt_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_not_empty),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
